@@ rtl/lzwc_pkg.sv @@
// ----------------------------------------------------------------------------
// lzwc_pkg: shared types and constants
// Payload structs, controller states and the command and status bundles that
// join the controller and the datapath of the LZW compress encoder.
// ----------------------------------------------------------------------------
package lzwc_pkg;

  localparam int MAX_CODE_BITS_DEF = 16;
  localparam int HASH_ENTRIES_DEF  = 131072;
  localparam int MIN_WIDTH         = 9;
  localparam int CODE_START        = 257;
  localparam int GROUP_INIT        = 24;
  localparam int EPOCH_W           = 8;
  localparam int WID_W             = 5;

  localparam logic [7:0] HDR_MAGIC0     = 8'h1F;
  localparam logic [7:0] HDR_MAGIC1     = 8'h9D;
  localparam logic [7:0] HDR_BLOCK_MODE = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       width_error;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HDR,
    S_DISPATCH,
    S_PAD,
    S_READ,
    S_CMP,
    S_DRAIN,
    S_CLOSE,
    S_END_DRAIN,
    S_END_CLOSE
  } state_t;

  typedef struct packed {
    logic take_in;
    logic put_hdr;
    logic put_drain;
    logic put_flush;
    logic close;
    logic set_prefix;
    logic load_idx;
    logic next_idx;
    logic hit;
    logic miss;
    logic end_code;
    logic pad_step;
    logic widen;
    logic thr_never;
    logic stream_rst;
    logic clr_write;
  } cmd_t;

  typedef struct packed {
    logic can_put;
    logic slot_free;
    logic pend_valid;
    logic acc_ge8;
    logic acc_nz;
    logic pad_zero;
    logic have_prefix;
    logic header_sent;
    logic hdr_last;
    logic is_end;
    logic need_widen;
    logic at_max;
    logic hit;
    logic empty;
    logic epoch_wrap;
    logic clr_last;
  } status_t;

endpackage

@@ rtl/lzwc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lzwc_ctrl: encoder sequencer
// Steps one source item through header, widening pad, dictionary probe,
// code packing and byte drain; runs the dictionary clearing pass.
// ----------------------------------------------------------------------------
module lzwc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lzwc_pkg::status_t sts,
  output lzwc_pkg::cmd_t    cmd
);
  import lzwc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_nxt   = sts.header_sent ? S_DISPATCH : S_HDR;
        end
      end
      S_HDR: begin
        if (sts.can_put) begin
          cmd.put_hdr = 1'b1;
          if (sts.hdr_last) state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.is_end) begin
          cmd.end_code = sts.have_prefix;
          state_nxt    = S_END_DRAIN;
        end else if (!sts.have_prefix) begin
          cmd.set_prefix = 1'b1;
          state_nxt      = S_CLOSE;
        end else begin
          cmd.load_idx = 1'b1;
          if (sts.need_widen && !sts.at_max) begin
            state_nxt = S_PAD;
          end else begin
            cmd.thr_never = sts.need_widen;
            state_nxt     = S_READ;
          end
        end
      end
      S_PAD: begin
        if (sts.acc_ge8) begin
          cmd.put_drain = sts.can_put;
        end else if (sts.pad_zero) begin
          cmd.widen = 1'b1;
          state_nxt = S_READ;
        end else begin
          cmd.pad_step = 1'b1;
        end
      end
      S_READ: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (sts.hit) begin
          cmd.hit   = 1'b1;
          state_nxt = S_CLOSE;
        end else if (sts.empty) begin
          cmd.miss  = 1'b1;
          state_nxt = S_DRAIN;
        end else begin
          cmd.next_idx = 1'b1;
          state_nxt    = S_READ;
        end
      end
      S_DRAIN: begin
        if (sts.acc_ge8) begin
          cmd.put_drain = sts.can_put;
        end else begin
          state_nxt = S_CLOSE;
        end
      end
      S_CLOSE: begin
        if (!sts.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (sts.slot_free) begin
          cmd.close = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_END_DRAIN: begin
        if (sts.acc_ge8) begin
          cmd.put_drain = sts.can_put;
        end else if (sts.acc_nz) begin
          cmd.put_flush = sts.can_put;
        end else begin
          state_nxt = S_END_CLOSE;
        end
      end
      S_END_CLOSE: begin
        if (!sts.pend_valid || sts.slot_free) begin
          cmd.close      = sts.pend_valid;
          cmd.stream_rst = 1'b1;
          state_nxt      = sts.epoch_wrap ? S_CLEAR : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

@@ rtl/lzwc_dp.sv @@
// ----------------------------------------------------------------------------
// lzwc_dp: encoder datapath
// Holds the stream state, the dictionary memory with epoch tags, the bit
// packer with per-width group counters, and the byte output stage.
// ----------------------------------------------------------------------------
module lzwc_dp #(
  parameter int MAX_CODE_BITS = lzwc_pkg::MAX_CODE_BITS_DEF,
  parameter int HASH_ENTRIES  = lzwc_pkg::HASH_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lzwc_pkg::in_item_t  in_data,
  input  lzwc_pkg::cmd_t      cmd,
  output lzwc_pkg::status_t   sts,
  input  logic                out_ready,
  output logic                out_valid,
  output lzwc_pkg::out_item_t out_data
);
  import lzwc_pkg::*;

  localparam int CODE_W = MAX_CODE_BITS;
  localparam int KEY_W  = CODE_W + 8;
  localparam int IDX_W  = $clog2(HASH_ENTRIES);
  localparam int FOLD_W = 2 * IDX_W;
  localparam int ACC_W  = CODE_W + 8;
  localparam int CNT_W  = $clog2(ACC_W + 1);
  localparam int NW     = MAX_CODE_BITS - MIN_WIDTH + 1;
  localparam int GRP_W  = $clog2(8 * MAX_CODE_BITS);
  localparam int ENT_W  = EPOCH_W + KEY_W + CODE_W;
  localparam logic [IDX_W:0] HE = (IDX_W + 1)'(HASH_ENTRIES);

  function automatic logic [CODE_W:0] thr_for(input logic [WID_W-1:0] w);
    logic [CODE_W:0] base;
    base = (CODE_W + 1)'(1) << w;
    if (w < WID_W'(MAX_CODE_BITS)) begin
      return base + (CODE_W + 1)'(1);
    end
    return base;
  endfunction

  logic [7:0]             byte_r;
  logic                   end_r;
  logic [CODE_W-1:0]      prefix_r;
  logic                   have_prefix_r;
  logic [CODE_W:0]        nfc_r;
  logic [WID_W-1:0]       width_r;
  logic [CODE_W:0]        thr_r;
  logic                   thr_never_r;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic [ACC_W-1:0]       err_r, err_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [GRP_W-1:0]       grp_r [NW];
  logic [GRP_W-1:0]       grp_nxt [NW];
  logic                   hdr_sent_r;
  logic [1:0]             hdr_cnt_r;
  logic [IDX_W-1:0]       idx_r;
  logic [EPOCH_W-1:0]     epoch_r;
  logic [IDX_W-1:0]       clr_r;
  logic [ENT_W-1:0]       rd_r;
  logic                   pend_valid_r;
  logic [7:0]             pend_byte_r;
  logic                   pend_err_r;
  logic                   out_valid_r;
  out_item_t              out_r;
  logic [ENT_W-1:0]       mem [HASH_ENTRIES];

  logic [KEY_W-1:0]       key;
  logic [FOLD_W-1:0]      key_ext;
  logic [IDX_W:0]         hash_raw;
  logic [IDX_W-1:0]       hash;
  logic [IDX_W-1:0]       idx_inc;
  logic [CODE_W:0]        mask_full;
  logic [CODE_W-1:0]      mask;
  logic                   code_err;
  logic [4:0]             adv;
  logic [GRP_W:0]         span;
  logic [GRP_W-1:0]       rem;
  logic [GRP_W:0]         pad;
  logic [3:0]             pad_k;
  logic                   put;
  logic [7:0]             put_byte;
  logic                   put_err;
  logic                   do_close;
  logic                   load_out;
  logic                   slot_free;
  logic                   room;
  logic                   we;
  logic [IDX_W-1:0]       wa;
  logic [ENT_W-1:0]       wd;
  logic [EPOCH_W-1:0]     rd_tag;
  logic [KEY_W-1:0]       rd_key;
  logic [CODE_W-1:0]      rd_code;
  logic [GRP_W:0]         gsum;
  logic [GRP_W:0]         gmod;
  logic [IDX_W:0]         idx_p1;

  assign key     = {prefix_r, byte_r};
  assign key_ext = FOLD_W'(key);
  assign hash_raw = {1'b0, key_ext[IDX_W-1:0] ^ key_ext[FOLD_W-1:IDX_W]};
  assign hash    = (hash_raw >= HE) ? IDX_W'(hash_raw - HE) : hash_raw[IDX_W-1:0];
  assign idx_p1  = {1'b0, idx_r} + (IDX_W + 1)'(1);
  assign idx_inc = (idx_p1 == HE) ? '0 : idx_p1[IDX_W-1:0];

  assign mask_full = ((CODE_W + 1)'(1) << width_r) - (CODE_W + 1)'(1);
  assign mask      = mask_full[CODE_W-1:0];
  assign code_err  = |(prefix_r & ~mask);

  assign {rd_tag, rd_key, rd_code} = rd_r;

  // pad distance to the next group boundary of the active width
  always_comb begin
    span = '0;
    rem  = '0;
    for (int j = 0; j < NW; j++) begin
      if (width_r == WID_W'(MIN_WIDTH + j)) begin
        span = (GRP_W + 1)'(8 * (MIN_WIDTH + j));
        rem  = grp_r[j];
      end
    end
    pad   = (rem == '0) ? '0 : span - (GRP_W + 1)'(rem);
    pad_k = (pad > (GRP_W + 1)'(8)) ? 4'd8 : pad[3:0];
  end

  // bit packer
  always_comb begin
    acc_nxt = acc_r;
    err_nxt = err_r;
    cnt_nxt = cnt_r;
    adv     = '0;
    if (cmd.end_code || cmd.miss) begin
      acc_nxt = acc_r | (ACC_W'(prefix_r & mask) << cnt_r);
      err_nxt = err_r | (ACC_W'(mask & {CODE_W{code_err}}) << cnt_r);
      cnt_nxt = cnt_r + CNT_W'(width_r);
      adv     = width_r;
    end else if (cmd.pad_step) begin
      cnt_nxt = cnt_r + CNT_W'(pad_k);
      adv     = 5'(pad_k);
    end else if (cmd.put_drain) begin
      acc_nxt = acc_r >> 8;
      err_nxt = err_r >> 8;
      cnt_nxt = cnt_r - CNT_W'(8);
    end else if (cmd.put_flush) begin
      acc_nxt = '0;
      err_nxt = '0;
      cnt_nxt = '0;
    end
    for (int j = 0; j < NW; j++) begin
      gsum = (GRP_W + 1)'(grp_r[j]) + (GRP_W + 1)'(adv);
      gmod = (gsum >= (GRP_W + 1)'(8 * (MIN_WIDTH + j))) ?
             gsum - (GRP_W + 1)'(8 * (MIN_WIDTH + j)) : gsum;
      grp_nxt[j] = gmod[GRP_W-1:0];
    end
  end

  // byte selection
  always_comb begin
    put      = cmd.put_hdr | cmd.put_drain | cmd.put_flush;
    put_byte = acc_r[7:0];
    put_err  = |err_r[7:0];
    if (cmd.put_hdr) begin
      put_err = 1'b0;
      case (hdr_cnt_r)
        2'd0:    put_byte = HDR_MAGIC0;
        2'd1:    put_byte = HDR_MAGIC1;
        default: put_byte = HDR_BLOCK_MODE | 8'(MAX_CODE_BITS);
      endcase
    end
  end

  assign slot_free = !out_valid_r || out_ready;
  assign do_close  = cmd.close && pend_valid_r;
  assign load_out  = (put || do_close) && pend_valid_r;
  assign room      = !nfc_r[CODE_W];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.stream_rst) begin
      end_r         <= 1'b0;
      byte_r        <= '0;
      prefix_r      <= '0;
      have_prefix_r <= 1'b0;
      nfc_r         <= (CODE_W + 1)'(CODE_START);
      width_r       <= WID_W'(MIN_WIDTH);
      thr_r         <= thr_for(WID_W'(MIN_WIDTH));
      thr_never_r   <= 1'b0;
      acc_r         <= '0;
      err_r         <= '0;
      cnt_r         <= '0;
      for (int j = 0; j < NW; j++) grp_r[j] <= GRP_W'(GROUP_INIT);
      hdr_sent_r    <= 1'b0;
      hdr_cnt_r     <= '0;
    end else begin
      acc_r <= acc_nxt;
      err_r <= err_nxt;
      cnt_r <= cnt_nxt;
      for (int j = 0; j < NW; j++) grp_r[j] <= grp_nxt[j];
      if (cmd.take_in) begin
        byte_r <= in_data.data_byte;
        end_r  <= in_data.end_of_stream;
      end
      if (cmd.put_hdr) begin
        hdr_cnt_r <= (hdr_cnt_r == 2'd2) ? 2'd0 : hdr_cnt_r + 2'd1;
        if (hdr_cnt_r == 2'd2) hdr_sent_r <= 1'b1;
      end
      if (cmd.set_prefix) begin
        prefix_r      <= CODE_W'(byte_r);
        have_prefix_r <= 1'b1;
      end
      if (cmd.hit) prefix_r <= rd_code;
      if (cmd.miss) begin
        prefix_r <= CODE_W'(byte_r);
        if (room) nfc_r <= nfc_r + (CODE_W + 1)'(1);
      end
      if (cmd.widen) begin
        width_r <= width_r + WID_W'(1);
        thr_r   <= thr_for(width_r + WID_W'(1));
      end
      if (cmd.thr_never) thr_never_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r <= '0;
      clr_r   <= '0;
      idx_r   <= '0;
    end else begin
      if (cmd.stream_rst) epoch_r <= epoch_r + EPOCH_W'(1);
      if (cmd.clr_write) begin
        clr_r <= sts.clr_last ? '0 : clr_r + IDX_W'(1);
        if (sts.clr_last) epoch_r <= EPOCH_W'(1);
      end
      if (cmd.load_idx) idx_r <= hash;
      else if (cmd.next_idx) idx_r <= idx_inc;
    end
  end

  // dictionary memory
  assign we = cmd.clr_write || (cmd.miss && room);
  assign wa = cmd.clr_write ? clr_r : idx_r;
  assign wd = cmd.clr_write ? '0 : {epoch_r, key, nfc_r[CODE_W-1:0]};

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[idx_r];
  end

  // hold one byte back so the last one of an item can be marked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (put) pend_valid_r <= 1'b1;
      else if (do_close) pend_valid_r <= 1'b0;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put) begin
      pend_byte_r <= put_byte;
      pend_err_r  <= put_err;
    end
    if (load_out) begin
      out_r.out_byte    <= pend_byte_r;
      out_r.width_error <= pend_err_r;
      out_r.last_of_run <= do_close;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    sts             = '0;
    sts.can_put     = !pend_valid_r || slot_free;
    sts.slot_free   = slot_free;
    sts.pend_valid  = pend_valid_r;
    sts.acc_ge8     = cnt_r >= CNT_W'(8);
    sts.acc_nz      = cnt_r != '0;
    sts.pad_zero    = pad == '0;
    sts.have_prefix = have_prefix_r;
    sts.header_sent = hdr_sent_r;
    sts.hdr_last    = hdr_cnt_r == 2'd2;
    sts.is_end      = end_r;
    sts.need_widen  = !thr_never_r && (nfc_r >= thr_r) &&
                      (prefix_r < CODE_W'(CODE_START));
    sts.at_max      = width_r == WID_W'(MAX_CODE_BITS);
    sts.hit         = (rd_tag == epoch_r) && (rd_key == key);
    sts.empty       = rd_tag != epoch_r;
    sts.epoch_wrap  = &epoch_r;
    sts.clr_last    = {1'b0, clr_r} == HE - (IDX_W + 1)'(1);
  end

endmodule

@@ rtl/lzw_unix_compress_encoder_top.sv @@
// ----------------------------------------------------------------------------
// lzw_unix_compress_encoder_top: block-mode .Z LZW encoder
// Source bytes enter on in_ (valid/ready, one byte or an end marker a beat);
// compressed bytes leave on out_ (valid/ready, one byte a beat, header first,
// last_of_run on the final byte of each input beat).
// A source byte that only starts a prefix needs no dictionary probe; any
// other byte probes slot after slot until a hit or an empty slot, and a miss
// then drains the whole bytes that its code completes. A width change first
// pads the code stream to the group boundary of the old width. The probe loop
// (read slot, compare) runs through the registered read of the dictionary.
// The first beat of a stream adds 3 header bytes; an end beat flushes the
// pending code and partial byte and starts a new stream.
// After reset the dictionary is swept with in_ready low; the same sweep
// runs after every 255th end beat.
// When the receiver stalls, one byte waits in the output register and one
// more is held; the encoder then waits and in_ready stays low.
// ----------------------------------------------------------------------------
module lzw_unix_compress_encoder_top #(
  parameter int MAX_CODE_BITS = lzwc_pkg::MAX_CODE_BITS_DEF,
  parameter int HASH_ENTRIES  = lzwc_pkg::HASH_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lzwc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lzwc_pkg::out_item_t out_data
);
  import lzwc_pkg::*;

  cmd_t    cmd;
  status_t sts;

  lzwc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzwc_dp #(
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .HASH_ENTRIES  (HASH_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: LZW compress encoder stream check
// Feeds source bytes and end markers through the valid/ready input and checks
// every compressed output byte against an in-bench encoder that packs
// header, codes, width-change padding and flush bytes.
// ----------------------------------------------------------------------------
module testbench;
  import lzwc_pkg::*;

  localparam int MAXB        = MAX_CODE_BITS_DEF;
  localparam int GROUP_MOD   = 5765760;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    in_item_t item;
    bit       drain;
  } src_beat_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  lzw_unix_compress_encoder_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  src_beat_t src_q[$];
  out_item_t byte_q[$];
  out_item_t run_bytes[$];
  int        code_of[int];

  int  nfree, width, thresh, prefix, pbyte, pbits, gpos;
  bit  has_prefix, perr, hdr_done;
  int  fails, beats_in, beats_out, ends_in, widenings, oversized;
  int  cycles;
  int  in_gap, out_stall;
  bit  no_idle;

  function automatic int thresh_for(int w);
    return (w < MAXB) ? (1 << w) + 1 : (1 << w);
  endfunction

  task automatic stream_init();
    code_of.delete();
    nfree      = CODE_START;
    width      = MIN_WIDTH;
    thresh     = thresh_for(MIN_WIDTH);
    has_prefix = 0;
    prefix     = 0;
    pbyte      = 0;
    pbits      = 0;
    perr       = 0;
    gpos       = GROUP_INIT;
    hdr_done   = 0;
  endtask

  task automatic emit_byte(logic [7:0] b, bit err);
    out_item_t o;
    o.out_byte    = b;
    o.last_of_run = 1'b0;
    o.width_error = err;
    run_bytes = {run_bytes, o};
  endtask

  task automatic emit_bit(bit b, bit err);
    pbyte |= int'(b) << pbits;
    perr  |= err;
    pbits++;
    gpos++;
    if (gpos >= GROUP_MOD) gpos = 0;
    if (pbits == 8) begin
      emit_byte(pbyte[7:0], perr);
      pbyte = 0;
      pbits = 0;
      perr  = 0;
    end
  endtask

  task automatic emit_code(int code);
    bit err;
    err = code > ((1 << width) - 1);
    if (err) oversized++;
    for (int i = 0; i < width; i++) emit_bit(code[i], err);
  endtask

  task automatic encode_beat(in_item_t it);
    int span, pad, key;
    run_bytes.delete();
    if (!hdr_done) begin
      emit_byte(HDR_MAGIC0, 0);
      emit_byte(HDR_MAGIC1, 0);
      emit_byte(HDR_BLOCK_MODE | 8'(MAXB), 0);
      hdr_done = 1;
    end
    if (it.end_of_stream) begin
      if (has_prefix) emit_code(prefix);
      if (pbits != 0) emit_byte(pbyte[7:0], perr);
      stream_init();
    end else if (!has_prefix) begin
      prefix     = it.data_byte;
      has_prefix = 1;
    end else begin
      if (nfree >= thresh && prefix < CODE_START) begin
        if (width < MAXB) begin
          span = 8 * width;
          pad  = (gpos % span == 0) ? 0 : span - gpos % span;
          repeat (pad) emit_bit(0, 0);
          width++;
          thresh = thresh_for(width);
          widenings++;
        end else begin
          thresh = (1 << MAXB) + 65536;
        end
      end
      key = ((prefix & 16'hFFFF) << 8) | it.data_byte;
      if (code_of.exists(key)) begin
        prefix = code_of[key];
      end else begin
        emit_code(prefix);
        if (nfree < (1 << MAXB)) begin
          code_of[key] = nfree;
          nfree++;
        end
        prefix = it.data_byte;
      end
    end
    if (run_bytes.size() > 0) run_bytes[run_bytes.size() - 1].last_of_run = 1'b1;
    foreach (run_bytes[i]) byte_q = {byte_q, run_bytes[i]};
  endtask

  task automatic add_byte(int b);
    src_beat_t s;
    s.item.data_byte     = b[7:0];
    s.item.end_of_stream = 1'b0;
    s.drain              = 0;
    src_q = {src_q, s};
  endtask

  task automatic add_end(bit drain_first);
    src_beat_t s;
    s.item.data_byte     = 8'($urandom_range(0, 255));
    s.item.end_of_stream = 1'b1;
    s.drain              = drain_first;
    src_q = {src_q, s};
  endtask

  initial begin
    clk    = 0;
    cycles = 0;
    forever begin
      #2 clk = ~clk;
      if (clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  // driver
  always @(posedge clk) begin
    src_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        encode_beat(in_data);
        beats_in++;
        if (in_data.end_of_stream) ends_in++;
        if (beats_in % 40 == 0) no_idle = ~no_idle;
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (src_q.size() > 0 && !(src_q[0].drain && byte_q.size() > 0)) begin
          nxt       = src_q.pop_front();
          in_data  <= nxt.item;
          in_valid <= 1'b1;
          in_gap   <= no_idle ? 0 : $urandom_range(0, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall  = 0;
    end else begin
      if (out_valid && out_ready) begin
        beats_out++;
        if (byte_q.size() == 0) begin
          $error("unexpected out beat: out_byte %h", out_data.out_byte);
          fails++;
        end else begin
          want = byte_q.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, out_data.out_byte);
            fails++;
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %b, got %b", want.last_of_run,
                   out_data.last_of_run);
            fails++;
          end
          if (out_data.width_error !== want.width_error) begin
            $error("width_error: expected %b, got %b", want.width_error,
                   out_data.width_error);
            fails++;
          end
        end
        out_stall = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int len, alpha;
    rst_n     = 0;
    fails = 0; beats_in = 0; beats_out = 0; ends_in = 0;
    widenings = 0; oversized = 0; no_idle = 0;
    stream_init();

    // directed: end first, single bytes at extremes, repeats for dictionary hits
    add_end(0);
    add_byte(0);
    add_end(0);
    add_byte(255);
    add_byte(255);
    add_end(0);
    for (int i = 0; i < 8; i++) add_byte(8'h61);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h55);
    add_byte(8'hAA);
    add_end(1);
    add_end(0);

    // long stream: steady dictionary growth
    for (int i = 0; i < 80; i++) add_byte($urandom_range(0, 255));
    add_end(0);

    // random streams of random length and alphabet
    while (src_q.size() < 150) begin
      len   = $urandom_range(0, 12);
      alpha = ($urandom_range(0, 1) == 0) ? 3 : 255;
      for (int i = 0; i < len; i++) add_byte($urandom_range(0, alpha));
      add_end($urandom_range(0, 5) == 0);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    wait (src_q.size() == 0 && !in_valid && byte_q.size() == 0);
    repeat (200) @(posedge clk);
    $display("Sent %0d beats (%0d stream ends), checked %0d output bytes", beats_in,
             ends_in, beats_out);
    $display("Width changes: %0d, oversized codes: %0d", widenings, oversized);
    if (fails == 0 && byte_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      if (byte_q.size() != 0) $error("%0d expected bytes never arrived", byte_q.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
